FILE: rtl/core/saop_pkg.sv
// Shared types, constants and the object table of the advertisement object parser.
package saop_pkg;

    // Defaults and sizes
    localparam int MAX_RESULTS_DEF = 8;
    localparam int QUEUE_DEPTH     = 4;
    localparam int TABLE_SIZE      = 20;

    localparam int BYTE_W  = 8;
    localparam int ACC_W   = 24;
    localparam int VALUE_W = 25;
    localparam int QTY_W   = 3;
    localparam int IDX_W   = 5;
    localparam int STAT_W  = 2;

    // Result kinds
    localparam logic KIND_MEAS   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Frame status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_TRUNCATED = 2'd1;
    localparam logic [STAT_W-1:0] ST_ENCRYPTED = 2'd2;

    // Quantity codes
    localparam logic [QTY_W-1:0] QTY_BATTERY  = 3'd0;
    localparam logic [QTY_W-1:0] QTY_AIR_TEMP = 3'd1;
    localparam logic [QTY_W-1:0] QTY_HUMIDITY = 3'd2;
    localparam logic [QTY_W-1:0] QTY_PRESSURE = 3'd3;
    localparam logic [QTY_W-1:0] QTY_ILLUM    = 3'd4;
    localparam logic [QTY_W-1:0] QTY_SOIL     = 3'd5;
    localparam logic [QTY_W-1:0] QTY_MAX      = QTY_SOIL;
    localparam logic [QTY_W-1:0] QTY_NONE     = 3'd7;

    // Encryption flag position in the device-info byte
    localparam int INFO_ENC_BIT = 0;

    // Scale factor for whole-unit readings
    localparam logic signed [7:0] CENTI_SCALE = 8'sd100;

    typedef enum logic [2:0] {
        PH_INFO      = 3'd0,
        PH_ID        = 3'd1,
        PH_VALUE     = 3'd2,
        PH_DRAIN_OK  = 3'd3,
        PH_DRAIN_ENC = 3'd4
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] id;
        logic [1:0]        width;
        logic              is_signed;
        logic              times100;
        logic [QTY_W-1:0]  qty;
    } obj_row_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } lookup_t;

    // One record from the front to the back: an optional measurement and an
    // optional end-of-frame status, in that order
    typedef struct packed {
        logic                      meas_vld;
        logic [QTY_W-1:0]          qty;
        logic signed [VALUE_W-1:0] value;
        logic                      times100;
        logic                      end_vld;
        logic [STAT_W-1:0]         status;
    } work_t;

    // Object table row by index
    function automatic obj_row_t obj_row(input logic [IDX_W-1:0] idx);
        obj_row_t r;
        case (idx)
            5'd1:    r = '{8'h01, 2'd1, 1'b0, 1'b1, QTY_BATTERY};
            5'd2:    r = '{8'h02, 2'd2, 1'b1, 1'b0, QTY_AIR_TEMP};
            5'd3:    r = '{8'h03, 2'd2, 1'b0, 1'b0, QTY_HUMIDITY};
            5'd4:    r = '{8'h04, 2'd3, 1'b0, 1'b0, QTY_PRESSURE};
            5'd5:    r = '{8'h05, 2'd3, 1'b0, 1'b0, QTY_ILLUM};
            5'd6:    r = '{8'h06, 2'd2, 1'b0, 1'b0, QTY_NONE};
            5'd7:    r = '{8'h07, 2'd2, 1'b0, 1'b0, QTY_NONE};
            5'd8:    r = '{8'h08, 2'd2, 1'b1, 1'b0, QTY_NONE};
            5'd9:    r = '{8'h09, 2'd1, 1'b0, 1'b1, QTY_NONE};
            5'd10:   r = '{8'h0A, 2'd3, 1'b0, 1'b0, QTY_NONE};
            5'd11:   r = '{8'h0B, 2'd3, 1'b0, 1'b0, QTY_NONE};
            5'd12:   r = '{8'h0C, 2'd2, 1'b0, 1'b0, QTY_NONE};
            5'd13:   r = '{8'h0D, 2'd2, 1'b0, 1'b1, QTY_NONE};
            5'd14:   r = '{8'h0E, 2'd2, 1'b0, 1'b1, QTY_NONE};
            5'd15:   r = '{8'h12, 2'd2, 1'b0, 1'b1, QTY_NONE};
            5'd16:   r = '{8'h13, 2'd2, 1'b0, 1'b1, QTY_NONE};
            5'd17:   r = '{8'h14, 2'd2, 1'b0, 1'b0, QTY_SOIL};
            5'd18:   r = '{8'h2E, 2'd1, 1'b0, 1'b1, QTY_HUMIDITY};
            5'd19:   r = '{8'h2F, 2'd1, 1'b0, 1'b1, QTY_SOIL};
            default: r = '{8'h00, 2'd1, 1'b0, 1'b1, QTY_NONE};
        endcase
        return r;
    endfunction

    // Match an object id against every table row
    function automatic lookup_t id_lookup(input logic [BYTE_W-1:0] id);
        lookup_t  res;
        obj_row_t r;
        res = '0;
        for (int i = TABLE_SIZE - 1; i >= 0; i--)
        begin
            r = obj_row(IDX_W'(i));
            if (r.id == id)
            begin
                res.hit = 1'b1;
                res.idx = IDX_W'(i);
            end
        end
        return res;
    endfunction

    // Sign- or zero-extend an assembled value by its row's width
    function automatic logic signed [VALUE_W-1:0] extend_raw(input logic [ACC_W-1:0] a,
                                                             input obj_row_t r);
        logic signed [VALUE_W-1:0] v;
        unique case (r.width)
            2'd1:    v = {{(VALUE_W-8){r.is_signed & a[7]}}, a[7:0]};
            2'd2:    v = {{(VALUE_W-16){r.is_signed & a[15]}}, a[15:0]};
            default: v = {r.is_signed & a[23], a};
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/saop_ifs.sv
// Valid/ready channel interfaces for payload bytes and parser results.
interface saop_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface saop_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [2:0]  quantity;
    logic signed [24:0] value_centi;
    logic [1:0]  status;
    logic        last_of_step;

    modport source (output valid, output result_kind, output quantity, output value_centi,
                    output status, output last_of_step, input ready);
    modport sink   (input valid, input result_kind, input quantity, input value_centi,
                    input status, input last_of_step, output ready);
endinterface

FILE: rtl/core/saop_front.sv
// Front end: accepts payload bytes, tracks frame parsing and builds work records.
module saop_front #(
    parameter int MAX_RESULTS = saop_pkg::MAX_RESULTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    saop_byte_if.sink         payload,
    output saop_pkg::work_t   work,
    output logic              work_vld,
    input  logic              work_ready
);
    import saop_pkg::*;

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    phase_t             phase_reg, phase_next;
    logic [IDX_W-1:0]   entry_reg, entry_next;
    logic [1:0]         bcnt_reg, bcnt_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               accept;
    lookup_t            lk;
    obj_row_t           row;
    logic [ACC_W-1:0]   acc_sum;
    logic [1:0]         bcnt_inc;
    work_t              rec;

    assign payload.ready = work_ready;
    assign accept        = payload.valid && work_ready;

    assign lk       = id_lookup(payload.data_byte);
    assign row      = obj_row(entry_reg);
    assign acc_sum  = acc_reg | (ACC_W'(payload.data_byte) << {bcnt_reg, 3'b000});
    assign bcnt_inc = bcnt_reg + 2'd1;

    // Advance the parse state for the byte on the input
    always_comb
    begin
        phase_next = phase_reg;
        entry_next = entry_reg;
        bcnt_next  = bcnt_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        rec        = '0;
        unique case (phase_reg)
            PH_INFO:
            begin
                phase_next = payload.data_byte[INFO_ENC_BIT] ? PH_DRAIN_ENC : PH_ID;
            end
            PH_ID:
            begin
                if (lk.hit)
                begin
                    entry_next = lk.idx;
                    bcnt_next  = '0;
                    acc_next   = '0;
                    phase_next = PH_VALUE;
                end
                else
                begin
                    phase_next = PH_DRAIN_OK;
                end
            end
            PH_VALUE:
            begin
                if (bcnt_inc >= row.width)
                begin
                    if (row.qty != QTY_NONE && cnt_reg < CNT_W'(MAX_RESULTS))
                    begin
                        rec.meas_vld = 1'b1;
                        rec.qty      = row.qty;
                        rec.value    = extend_raw(acc_sum, row);
                        rec.times100 = row.times100;
                        cnt_next     = cnt_reg + CNT_W'(1);
                    end
                    phase_next = PH_ID;
                    bcnt_next  = '0;
                    acc_next   = '0;
                end
                else
                begin
                    acc_next  = acc_sum;
                    bcnt_next = bcnt_inc;
                end
            end
            PH_DRAIN_ENC:
            begin
                phase_next = PH_DRAIN_ENC;
            end
            default:
            begin
                phase_next = PH_DRAIN_OK;
            end
        endcase

        // Close the frame on its last byte
        if (payload.last_byte)
        begin
            rec.end_vld = 1'b1;
            priority if (phase_next == PH_DRAIN_ENC)
                rec.status = ST_ENCRYPTED;
            else if (phase_next == PH_VALUE)
                rec.status = ST_TRUNCATED;
            else
                rec.status = ST_OK;
            phase_next = PH_INFO;
            entry_next = '0;
            bcnt_next  = '0;
            acc_next   = '0;
            cnt_next   = '0;
        end
    end

    assign work     = rec;
    assign work_vld = accept && (rec.meas_vld || rec.end_vld);

    // Hold state between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_INFO;
            entry_reg <= '0;
            bcnt_reg  <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            entry_reg <= entry_next;
            bcnt_reg  <= bcnt_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/saop_queue.sv
// Short work-record queue between the front and back ends.
module saop_queue #(
    parameter int DEPTH = saop_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  saop_pkg::work_t  push_data,
    output logic             full,
    input  logic             pop,
    output saop_pkg::work_t  head,
    output logic             head_vld
);
    import saop_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign head_vld = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && head_vld;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/core/saop_back.sv
// Back end: scales values and delivers measurement and status results.
module saop_back (
    input  logic             clk,
    input  logic             rst_n,
    input  saop_pkg::work_t  head,
    input  logic             head_vld,
    output logic             pop,
    saop_result_if.source    results
);
    import saop_pkg::*;

    logic                       vld_reg, vld_next;
    logic                       meas_done_reg, meas_done_next;
    logic                       kind_reg, kind_next;
    logic [QTY_W-1:0]           qty_reg, qty_next;
    logic signed [VALUE_W-1:0]  val_reg, val_next;
    logic [STAT_W-1:0]          st_reg, st_next;
    logic                       last_reg, last_next;

    logic                       load;
    logic signed [31:0]         prod;
    logic signed [VALUE_W-1:0]  scaled;

    assign load   = head_vld && (!vld_reg || results.ready);
    assign prod   = head.value * CENTI_SCALE;
    assign scaled = head.times100 ? prod[VALUE_W-1:0] : head.value;

    // Pick the next result from the head record
    always_comb
    begin
        kind_next      = kind_reg;
        qty_next       = qty_reg;
        val_next       = val_reg;
        st_next        = st_reg;
        last_next      = last_reg;
        meas_done_next = meas_done_reg;
        pop            = 1'b0;
        if (head.meas_vld && !meas_done_reg)
        begin
            kind_next = KIND_MEAS;
            qty_next  = head.qty;
            val_next  = scaled;
            st_next   = ST_OK;
            last_next = !head.end_vld;
            if (load)
            begin
                pop            = !head.end_vld;
                meas_done_next = head.end_vld;
            end
        end
        else
        begin
            kind_next = KIND_STATUS;
            qty_next  = '0;
            val_next  = '0;
            st_next   = head.status;
            last_next = 1'b1;
            if (load)
            begin
                pop            = 1'b1;
                meas_done_next = 1'b0;
            end
        end
        vld_next = load ? 1'b1 : (results.ready ? 1'b0 : vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= 1'b0;
            meas_done_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            meas_done_reg <= meas_done_next;
        end
    end

    // Hold the output payload until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            qty_reg  <= qty_next;
            val_reg  <= val_next;
            st_reg   <= st_next;
            last_reg <= last_next;
        end
    end

    assign results.valid        = vld_reg;
    assign results.result_kind  = kind_reg;
    assign results.quantity     = qty_reg;
    assign results.value_centi  = val_reg;
    assign results.status       = st_reg;
    assign results.last_of_step = last_reg;

endmodule

FILE: rtl/core/sensor_advert_object_parser.sv
// Top level of the sensor advertisement object parser.
//
//  channel   | dir | payload                                                | handshake
//  ----------+-----+--------------------------------------------------------+-----------
//  payload   | in  | data_byte, last_byte                                   | valid/ready
//  results   | out | result_kind, quantity, value_centi, status, last_of_step | valid/ready
//
//  One byte is taken per cycle while the queue has room; the object-id match and value
//  assembly run in the front end in the same cycle. The queue is written at the accepting
//  edge, and the output register loads from the queue head when it is empty or its result is taken.
//  The back end delivers one result per cycle while the output is not stalled; a byte that
//  ends an object on the last byte of a frame yields a measurement and a status; the 4-entry queue absorbs it.
//  Reset returns the parser to expect a device-info byte and empties the queue.
//  Input stalls only when the queue is full; output stalls hold the output register.
module sensor_advert_object_parser #(
    parameter int MAX_RESULTS = saop_pkg::MAX_RESULTS_DEF,
    parameter int QUEUE_DEPTH = saop_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    saop_byte_if.sink       payload,
    saop_result_if.source   results
);
    import saop_pkg::*;

    work_t  work;
    logic   work_vld;
    logic   q_full;
    work_t  head;
    logic   head_vld;
    logic   pop;

    saop_front #(
        .MAX_RESULTS (MAX_RESULTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .payload    (payload),
        .work       (work),
        .work_vld   (work_vld),
        .work_ready (!q_full)
    );

    saop_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (work_vld),
        .push_data (work),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .head_vld  (head_vld)
    );

    saop_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .head_vld (head_vld),
        .pop      (pop),
        .results  (results)
    );

endmodule

FILE: rtl/core/saop_checker.sv
// Port-level checks of the parser's result stream, bound to the top level.
module saop_result_checks (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic              result_kind,
    input logic [2:0]        quantity,
    input logic signed [24:0] value_centi,
    input logic [1:0]        status,
    input logic              last_of_step
);
    import saop_pkg::*;

    // A stalled result stays valid and keeps its value and status
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_centi) && $stable(status))
        else $error("result changed while stalled");

    // Status results carry no measurement, hold a defined status code and always close the byte's results
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_STATUS |->
            quantity == '0 && value_centi == '0 && last_of_step &&
            (status == ST_OK || status == ST_TRUNCATED || status == ST_ENCRYPTED))
        else $error("malformed status result");

    // Measurements name a real quantity and carry no status
    a_meas_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_MEAS |-> quantity <= QTY_MAX && status == ST_OK)
        else $error("malformed measurement result");

    // Nothing is offered right after reset
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result offered out of reset");

endmodule

bind sensor_advert_object_parser saop_result_checks u_saop_result_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .result_kind  (results.result_kind),
    .quantity     (results.quantity),
    .value_centi  (results.value_centi),
    .status       (results.status),
    .last_of_step (results.last_of_step)
);

FILE: tb/saop_checker.sv
// Predictor and result checker for the sensor advertisement object parser.
module saop_checker #(
    parameter int MAX_RESULTS = saop_pkg::MAX_RESULTS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    saop_byte_if   pay,
    saop_result_if res,
    output int     fail_count,
    output int     pending
);
    import saop_pkg::*;

    // Decoded properties of one object id
    typedef struct packed {
        logic             hit;
        logic [1:0]       width;
        logic             sgn;
        logic             x100;
        logic [QTY_W-1:0] qty;
    } obj_desc_t;

    // One result item as seen on the result channel
    typedef struct packed {
        logic                      kind;
        logic [QTY_W-1:0]          qty;
        logic signed [VALUE_W-1:0] value;
        logic [STAT_W-1:0]         status;
        logic                      last;
    } reading_t;

    reading_t          expected_q [$];
    phase_t            phase;
    obj_desc_t         cur_obj;
    int                bytes_got;
    logic [ACC_W-1:0]  acc;
    int                emitted;

    // Map an object id to its width, sign, scale and quantity
    function automatic obj_desc_t decode_id(input logic [7:0] id);
        obj_desc_t d;
        d = '0;
        d.hit = 1'b1;
        case (id)
            8'h00: d = '{1'b1, 2'd1, 1'b0, 1'b1, QTY_NONE};
            8'h01: d = '{1'b1, 2'd1, 1'b0, 1'b1, QTY_BATTERY};
            8'h02: d = '{1'b1, 2'd2, 1'b1, 1'b0, QTY_AIR_TEMP};
            8'h03: d = '{1'b1, 2'd2, 1'b0, 1'b0, QTY_HUMIDITY};
            8'h04: d = '{1'b1, 2'd3, 1'b0, 1'b0, QTY_PRESSURE};
            8'h05: d = '{1'b1, 2'd3, 1'b0, 1'b0, QTY_ILLUM};
            8'h06, 8'h07, 8'h0C:
                   d = '{1'b1, 2'd2, 1'b0, 1'b0, QTY_NONE};
            8'h08: d = '{1'b1, 2'd2, 1'b1, 1'b0, QTY_NONE};
            8'h09: d = '{1'b1, 2'd1, 1'b0, 1'b1, QTY_NONE};
            8'h0A, 8'h0B:
                   d = '{1'b1, 2'd3, 1'b0, 1'b0, QTY_NONE};
            8'h0D, 8'h0E, 8'h12, 8'h13:
                   d = '{1'b1, 2'd2, 1'b0, 1'b1, QTY_NONE};
            8'h14: d = '{1'b1, 2'd2, 1'b0, 1'b0, QTY_SOIL};
            8'h2E: d = '{1'b1, 2'd1, 1'b0, 1'b1, QTY_HUMIDITY};
            8'h2F: d = '{1'b1, 2'd1, 1'b0, 1'b1, QTY_SOIL};
            default: d = '0;
        endcase
        return d;
    endfunction

    // Turn the assembled raw bytes into hundredths of the unit
    function automatic logic signed [VALUE_W-1:0] to_centi(input obj_desc_t d,
                                                           input logic [ACC_W-1:0] a);
        int v;
        case (d.width)
            2'd1:    v = (d.sgn && a[7])  ? int'(a[7:0]) - 256     : int'(a[7:0]);
            2'd2:    v = (d.sgn && a[15]) ? int'(a[15:0]) - 65536  : int'(a[15:0]);
            default: v = (d.sgn && a[23]) ? int'(a) - 16777216     : int'(a);
        endcase
        if (d.x100)
            v = v * 100;
        return v[VALUE_W-1:0];
    endfunction

    task automatic clear_frame();
        phase     = PH_INFO;
        cur_obj   = '0;
        bytes_got = 0;
        acc       = '0;
        emitted   = 0;
    endtask

    // Advance the parser by one payload byte and queue the results it causes
    task automatic parse_byte(input logic [7:0] b, input logic is_last);
        reading_t  r;
        obj_desc_t d;
        int        n_before;
        n_before = expected_q.size();
        case (phase)
            PH_INFO:
                phase = b[INFO_ENC_BIT] ? PH_DRAIN_ENC : PH_ID;
            PH_ID:
            begin
                d = decode_id(b);
                if (d.hit)
                begin
                    cur_obj   = d;
                    bytes_got = 0;
                    acc       = '0;
                    phase     = PH_VALUE;
                end
                else
                    phase = PH_DRAIN_OK;
            end
            PH_VALUE:
            begin
                acc = acc | (ACC_W'(b) << (8 * bytes_got));
                bytes_got++;
                if (bytes_got >= int'(cur_obj.width))
                begin
                    // Emit mapped objects until the per-frame limit is hit
                    if (cur_obj.qty != QTY_NONE && emitted < MAX_RESULTS)
                    begin
                        r = '{KIND_MEAS, cur_obj.qty, to_centi(cur_obj, acc), ST_OK, 1'b0};
                        expected_q.push_back(r);
                        emitted++;
                    end
                    phase     = PH_ID;
                    bytes_got = 0;
                    acc       = '0;
                end
            end
            PH_DRAIN_ENC: ;
            default:
                phase = PH_DRAIN_OK;
        endcase

        // Close the frame with its status
        if (is_last)
        begin
            r = '{KIND_STATUS, 3'd0, '0, ST_OK, 1'b0};
            if (phase == PH_DRAIN_ENC)
                r.status = ST_ENCRYPTED;
            else if (phase == PH_VALUE)
                r.status = ST_TRUNCATED;
            expected_q.push_back(r);
            clear_frame();
        end

        // Flag the final result of this byte
        if (expected_q.size() > n_before)
        begin
            r = expected_q.pop_back();
            r.last = 1'b1;
            expected_q.push_back(r);
        end
    endtask

    // Compare one delivered result with the oldest expectation
    task automatic check_result();
        reading_t got;
        reading_t want;
        got = '{res.result_kind, res.quantity, res.value_centi, res.status, res.last_of_step};
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result kind=%0d qty=%0d value=%0d status=%0d last=%0d",
                     $time, got.kind, got.qty, got.value, got.status, got.last);
            fail_count++;
        end
        else
        begin
            want = expected_q.pop_front();
            if (got !== want)
            begin
                $display("%0t: mismatch expected kind=%0d qty=%0d value=%0d status=%0d last=%0d",
                         $time, want.kind, want.qty, want.value, want.status, want.last);
                $display("%0t:          actual   kind=%0d qty=%0d value=%0d status=%0d last=%0d",
                         $time, got.kind, got.qty, got.value, got.status, got.last);
                fail_count++;
            end
        end
    endtask

    // Drain results first: they always belong to earlier bytes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            expected_q.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
                check_result();
            if (pay.valid && pay.ready)
                parse_byte(pay.data_byte, pay.last_byte);
            pending <= expected_q.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// Top of the parser testbench: clock, reset, payload frames, result stalls and verdict.
module tb_top;
    import saop_pkg::*;

    localparam int RANDOM_BYTES = 450;

    // Object ids of the table, their value widths and the rows that report a quantity
    localparam logic [7:0] OBJ_IDS [20] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
                                            8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
                                            8'h0C, 8'h0D, 8'h0E, 8'h12, 8'h13, 8'h14,
                                            8'h2E, 8'h2F};
    localparam int OBJ_WIDTHS [20] = '{1, 1, 2, 2, 3, 3, 2, 2, 2, 1, 3, 3, 2, 2, 2, 2, 2, 2,
                                       1, 1};
    localparam int MAPPED_ROWS [8] = '{1, 2, 3, 4, 5, 17, 18, 19};

    logic clk = 1'b0;
    logic rst_n;
    logic no_gaps;
    logic steady_ready;
    int   hold_cnt;
    int   ready_roll;
    int   bytes_sent;
    int   fail_count;
    int   pending;
    logic [7:0] frame_q [$];

    saop_byte_if   byte_ch ();
    saop_result_if res_ch ();

    sensor_advert_object_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (byte_ch),
        .results (res_ch)
    );

    saop_checker #(
        .MAX_RESULTS (MAX_RESULTS_DEF)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pay        (byte_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    // Stall the result channel: mostly ready, short holds, now and then a long one, or always ready in steady mode
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            hold_cnt     <= 0;
        end
        else if (steady_ready)
            res_ch.ready <= 1'b1;
        else if (hold_cnt > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_cnt     <= hold_cnt - 1;
        end
        else
        begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 70)
                res_ch.ready <= 1'b1;
            else if (ready_roll < 92)
            begin
                res_ch.ready <= 1'b0;
                hold_cnt     <= $urandom_range(0, 2);
            end
            else
            begin
                res_ch.ready <= 1'b0;
                hold_cnt     <= $urandom_range(8, 40);
            end
        end
    end

    // Idle length before a byte: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Value bytes lean toward the extremes
    function automatic logic [7:0] pick_value_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return 8'h00;
        else if (roll < 30)
            return 8'hFF;
        else if (roll < 35)
            return 8'h80;
        else if (roll < 40)
            return 8'h7F;
        return 8'($urandom);
    endfunction

    // Offer one byte and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= is_last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // Send the queued frame with the last flag on its final byte
    task automatic send_frame();
        no_gaps = ($urandom_range(0, 7) == 0);
        steady_ready <= ($urandom_range(0, 9) == 0);
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    // Append an object id and the first keep bytes of its value
    task automatic push_object(input int row, input int keep);
        frame_q.push_back(OBJ_IDS[row]);
        for (int i = 0; i < keep; i++)
            frame_q.push_back(pick_value_byte());
    endtask

    // Build one random frame: mostly well-formed objects, some encrypted or noise
    task automatic build_random_frame();
        int kind;
        int nobj;
        int row;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            frame_q.push_back({7'($urandom), 1'b1});
            repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom));
        end
        else if (kind < 14)
        begin
            repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
        end
        else
        begin
            frame_q.push_back({7'($urandom), 1'b0});
            nobj = (kind < 24) ? $urandom_range(9, 13) : $urandom_range(0, 5);
            for (int k = 0; k < nobj; k++)
            begin
                if (kind < 24)
                    row = MAPPED_ROWS[$urandom_range(0, 7)];
                else if ($urandom_range(0, 99) < 88)
                    row = $urandom_range(0, 19);
                else
                begin
                    // Id from 0x15 up, mostly unknown, maybe followed by garbage that an unknown id makes ignored
                    frame_q.push_back(8'($urandom_range(8'h15, 8'hFF)));
                    repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
                    break;
                end
                // Cut the final object short now and then
                if (k == nobj - 1 && $urandom_range(0, 99) < 15)
                    push_object(row, $urandom_range(0, OBJ_WIDTHS[row] - 1));
                else
                    push_object(row, OBJ_WIDTHS[row]);
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        no_gaps           = 1'b0;
        steady_ready      = 1'b0;
        bytes_sent        = 0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.last_byte = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Info byte alone, plain then encrypted
        frame_q = '{8'h00};
        send_frame();
        frame_q = '{8'h01};
        send_frame();
        // Encrypted frame with bytes that must be ignored
        frame_q = '{8'hFF, 8'h02, 8'h34, 8'h12};
        send_frame();
        // Field extremes, object completing on the last byte
        frame_q = '{8'h40, 8'h01, 8'hFF, 8'h02, 8'h00, 8'h80, 8'h04, 8'hFF, 8'hFF, 8'hFF};
        send_frame();
        // Frame ending on an id, then inside a value
        frame_q = '{8'h00, 8'h2E, 8'h00, 8'h2F};
        send_frame();
        frame_q = '{8'h00, 8'h05, 8'h12};
        send_frame();
        // Unmapped object skipped, unknown id as the last byte
        frame_q = '{8'h00, 8'h0D, 8'h11, 8'h22, 8'h99};
        send_frame();

        // Hold off until the parser has delivered everything
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        for (int f = 1; bytes_sent < RANDOM_BYTES; f++)
        begin
            build_random_frame();
            send_frame();
            if (f % 40 == 0)
            begin
                byte_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
        end
        byte_ch.valid <= 1'b0;

        // Wait for the last results, then let the clock run on before the verdict
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("sensor_advert_object_parser test passed");
        else
            $display("sensor_advert_object_parser test failed");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #4000000;
        $display("sensor_advert_object_parser test failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/saop_pkg.sv
rtl/core/saop_ifs.sv
rtl/core/saop_front.sv
rtl/core/saop_queue.sv
rtl/core/saop_back.sv
rtl/core/sensor_advert_object_parser.sv
rtl/core/saop_checker.sv
tb/saop_checker.sv
tb/tb_top.sv
